// ----- rtl/bmid_pkg.sv -----
// Shared types, widths and constant tables for the mixed-radix index decoder.
package bmid_pkg;

   localparam int MAX_VARIABLES = 8;
   localparam int DEGREE_BITS   = 4;

   localparam int DATA_W    = MAX_VARIABLES * DEGREE_BITS;
   localparam int VCOUNT_W  = 4;
   localparam int DEG_W     = DEGREE_BITS;
   localparam int DEG_N     = 2 ** DEGREE_BITS;
   localparam int RADIX_W   = DEGREE_BITS + 1;
   localparam int BINOM_W   = DEG_N;
   localparam int RECIP_W   = DATA_W + 1;
   localparam int SUM_W     = 7;
   localparam int PROD_W    = 64;
   localparam int INV_W     = 32;
   localparam int DIV_W     = INV_W + 1;
   localparam int DIV_STEPS = DIV_W;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VARIABLE_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DEGREES    = 1'd1;

   localparam logic [VCOUNT_W-1:0] VARIABLE_COUNT_RESET = 4'd1;
   localparam logic [DATA_W-1:0]   MAX_DEGREES_RESET    = 32'h1111_1111;

   typedef logic [RECIP_W-1:0] recip_table_type [DEG_N];
   typedef logic [BINOM_W-1:0] binom_table_type [DEG_N * DEG_N];

   // floor(2^32 / radix), indexed by degree (radix = degree + 1), long division
   function automatic recip_table_type build_recip();
      recip_table_type tbl;
      longint unsigned rem;
      longint unsigned quo;
      longint unsigned radix;
      for (int i = 0; i < DEG_N; i++) begin
         radix = longint'(i + 1);
         rem   = 0;
         quo   = 0;
         for (int b = DATA_W; b >= 0; b--) begin
            rem = (rem << 1) | ((b == DATA_W) ? 64'd1 : 64'd0);
            quo = quo << 1;
            if (rem >= radix) begin
               rem = rem - radix;
               quo = quo | 64'd1;
            end
         end
         tbl[i] = RECIP_W'(quo);
      end
      return tbl;
   endfunction

   // C(n, k) indexed by {n, k}; zero where k > n
   function automatic binom_table_type build_binom();
      binom_table_type tbl;
      longint unsigned row [DEG_N];
      for (int j = 0; j < DEG_N; j++) begin
         row[j] = 0;
      end
      row[0] = 1;
      for (int n = 0; n < DEG_N; n++) begin
         for (int k = 0; k < DEG_N; k++) begin
            tbl[n * DEG_N + k] = BINOM_W'(row[k]);
         end
         for (int j = DEG_N - 1; j > 0; j--) begin
            row[j] = row[j] + row[j - 1];
         end
      end
      return tbl;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip();
   localparam binom_table_type BINOM_TABLE = build_binom();

   // first member is the top of the packed word
   typedef struct packed {
      logic                 index_out_of_range;
      logic [INV_W-1:0]     inverse_weight;
      logic                 product_saturated;
      logic [PROD_W-1:0]    binomial_product;
      logic [SUM_W-1:0]     degree_sum;
      logic                 is_linear;
      logic                 at_vertex;
      logic [DATA_W-1:0]    exponents;
   } bmid_result_type;

   localparam int RESULT_W = $bits(bmid_result_type);
   localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

   typedef struct packed {
      logic [DATA_W-1:0]  rem;
      logic [DATA_W-1:0]  exps;
      logic [SUM_W-1:0]   sum;
      logic               vertex;
      logic [PROD_W-1:0]  prod;
      logic               psat;
      logic [BINOM_W-1:0] binom;
   } bmid_digit_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [DIV_W-1:0] quo;
      logic [DIV_W-1:0] divisor;
      logic             big;
      bmid_result_type  res;
   } bmid_div_type;

endpackage

// ----- rtl/bmid_digit_cell.sv -----
// One mixed-radix digit cell: reciprocal divide by the radix, exponent, binomial.
module bmid_digit_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  bmid_pkg::bmid_digit_type     in_beat,
   input  logic [bmid_pkg::DEG_W-1:0]   degree,
   output logic                         out_valid,
   output bmid_pkg::bmid_digit_type     out_beat
);

   localparam int MUL_W  = bmid_pkg::RECIP_W + bmid_pkg::DATA_W;
   localparam int PMUL_W = bmid_pkg::PROD_W + bmid_pkg::BINOM_W;

   logic                              a_valid_ff;
   bmid_pkg::bmid_digit_type          a_beat_ff, a_beat_in;
   logic [bmid_pkg::DATA_W-1:0]       a_qest_ff, a_qest_in;
   logic                              b_valid_ff;
   bmid_pkg::bmid_digit_type          b_beat_ff, b_beat_in;

   logic [MUL_W-1:0]                  recip_full;
   logic [PMUL_W-1:0]                 prod_full;
   logic [bmid_pkg::RADIX_W-1:0]      radix;
   logic [bmid_pkg::RADIX_W:0]        qd_low;
   logic [bmid_pkg::RADIX_W:0]        r_est;
   logic [bmid_pkg::RADIX_W:0]        r_fix;
   logic                              fix;
   logic [bmid_pkg::DEG_W-1:0]        expo;

   // stage A: quotient estimate, fold previous binomial into the product
   always_comb begin
      recip_full = MUL_W'(in_beat.rem) * MUL_W'(bmid_pkg::RECIP_TABLE[degree]);
      prod_full  = PMUL_W'(in_beat.prod) * PMUL_W'(in_beat.binom);
      a_qest_in  = recip_full[bmid_pkg::DATA_W +: bmid_pkg::DATA_W];
      a_beat_in       = in_beat;
      a_beat_in.prod  = prod_full[bmid_pkg::PROD_W-1:0];
      a_beat_in.psat  = in_beat.psat | (|prod_full[PMUL_W-1:bmid_pkg::PROD_W]);
   end

   // stage B: estimate is exact or one low; remainder stays below 2*radix
   always_comb begin
      radix  = {1'b0, degree} + bmid_pkg::RADIX_W'(1);
      qd_low = (bmid_pkg::RADIX_W + 1)'(a_qest_ff[bmid_pkg::RADIX_W:0] * {1'b0, radix});
      r_est  = a_beat_ff.rem[bmid_pkg::RADIX_W:0] - qd_low;
      fix    = r_est >= {1'b0, radix};
      r_fix  = fix ? (r_est - {1'b0, radix}) : r_est;
      expo   = r_fix[bmid_pkg::DEG_W-1:0];
      b_beat_in        = a_beat_ff;
      b_beat_in.rem    = a_qest_ff + bmid_pkg::DATA_W'(fix);
      b_beat_in.exps   = {expo, a_beat_ff.exps[bmid_pkg::DATA_W-1:bmid_pkg::DEG_W]};
      b_beat_in.sum    = a_beat_ff.sum + bmid_pkg::SUM_W'(expo);
      b_beat_in.vertex = a_beat_ff.vertex & ((expo == '0) | (expo == degree));
      b_beat_in.binom  = bmid_pkg::BINOM_TABLE[{degree, expo}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_beat_ff <= a_beat_in;
         a_qest_ff <= a_qest_in;
         b_beat_ff <= b_beat_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_beat  = b_beat_ff;

endmodule

// ----- rtl/bmid_div_cell.sv -----
// One restoring-division step: one quotient bit of 2^32 / product.
module bmid_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  bmid_pkg::bmid_div_type  in_beat,
   output logic                    out_valid,
   output bmid_pkg::bmid_div_type  out_beat
);

   logic                            valid_ff;
   bmid_pkg::bmid_div_type          beat_ff, beat_in;
   logic [bmid_pkg::DIV_W:0]        trial;
   logic [bmid_pkg::DIV_W:0]        diff;
   logic                            take;

   always_comb begin
      trial = {in_beat.rem, in_beat.quo[bmid_pkg::DIV_W-1]};
      diff  = trial - {1'b0, in_beat.divisor};
      take  = !in_beat.big && (trial >= {1'b0, in_beat.divisor});
      beat_in     = in_beat;
      beat_in.rem = take ? diff[bmid_pkg::DIV_W-1:0] : trial[bmid_pkg::DIV_W-1:0];
      beat_in.quo = {in_beat.quo[bmid_pkg::DIV_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

// ----- rtl/bernstein_multi_index_decode_core.sv -----
// Mixed-radix coefficient index decoder: top level with config, cell chains and output skid.
//
// req_* carries one flat coefficient index per beat; rsp_* returns one result
// beat per index, in order. csr_* writes variable_count (index 0) or
// max_degrees (index 1); write only while no beat is in flight.
// An index passes 8 digit cells (two stages each, one variable per cell),
// one product stage, 33 divider cells (one reciprocal bit each) and the
// output register. A new index is taken every cycle while req_tready is
// high; the 33-step divider chain and the digit cells are fully pipelined,
// so sustained rate is one beat per cycle while rsp_tready stays high.
// Reset clears every valid bit and restores variable_count = 1 and
// max_degrees = 0x11111111.
// When rsp_tready is low the result holds on rsp_tdata; one more beat drops
// into a skid register and req_tready falls the next cycle, freezing the
// chain until the skid drains. No beat is lost or repeated.
module bernstein_multi_index_decode_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bmid_pkg::DATA_W-1:0]           req_tdata,   // flat_index
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // exponents, at_vertex, is_linear, degree_sum, binomial_product,
   // product_saturated, inverse_weight, index_out_of_range, zero pad
   output logic [bmid_pkg::TDATA_W-1:0]          rsp_tdata,
   input  logic                                  csr_we,
   input  logic [bmid_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bmid_pkg::DATA_W-1:0]           csr_wdata
);

   localparam int NV    = bmid_pkg::MAX_VARIABLES;
   localparam int NDIV  = bmid_pkg::DIV_STEPS;
   localparam int PMUL_W = bmid_pkg::PROD_W + bmid_pkg::BINOM_W;

   logic [bmid_pkg::VCOUNT_W-1:0]  var_count_ff;
   logic [bmid_pkg::DATA_W-1:0]    max_degrees_ff;
   logic [bmid_pkg::VCOUNT_W-1:0]  count_eff;
   logic [bmid_pkg::DEG_W-1:0]     degree [NV];

   logic                           enable;
   logic                           digit_valid [NV+1];
   bmid_pkg::bmid_digit_type       digit_beat  [NV+1];

   logic                           fold_valid_ff;
   bmid_pkg::bmid_div_type         fold_beat_ff, fold_beat_in;
   logic [PMUL_W-1:0]              fold_full;
   logic [bmid_pkg::PROD_W-1:0]    fold_prod;
   logic                           fold_sat;
   logic                           fold_oor;

   logic                           div_valid [NDIV+1];
   bmid_pkg::bmid_div_type         div_beat  [NDIV+1];

   logic [bmid_pkg::DIV_W:0]       rounded;
   bmid_pkg::bmid_result_type      last_res;
   logic                           push, pop;

   logic                           out_valid_ff;
   bmid_pkg::bmid_result_type      out_res_ff;
   logic                           skid_valid_ff;
   bmid_pkg::bmid_result_type      skid_res_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         var_count_ff   <= bmid_pkg::VARIABLE_COUNT_RESET;
         max_degrees_ff <= bmid_pkg::MAX_DEGREES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bmid_pkg::CSR_VARIABLE_COUNT: begin
               var_count_ff <= csr_wdata[bmid_pkg::VCOUNT_W-1:0];
            end
            bmid_pkg::CSR_MAX_DEGREES: begin
               max_degrees_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign count_eff = (var_count_ff > bmid_pkg::VCOUNT_W'(NV)) ?
                      bmid_pkg::VCOUNT_W'(NV) : var_count_ff;

   // unused variables act as radix 1
   for (genvar v = 0; v < NV; v++) begin : g_degree
      assign degree[v] = (bmid_pkg::VCOUNT_W'(v) < count_eff) ?
                         max_degrees_ff[v*bmid_pkg::DEG_W +: bmid_pkg::DEG_W] : '0;
   end

   assign enable     = !skid_valid_ff;
   assign req_tready = enable;

   assign digit_valid[0] = req_tvalid;
   assign digit_beat[0]  = '{rem: req_tdata, exps: '0, sum: '0, vertex: 1'b1,
                             prod: bmid_pkg::PROD_W'(1), psat: 1'b0,
                             binom: bmid_pkg::BINOM_W'(1)};

   for (genvar v = 0; v < NV; v++) begin : g_digit
      bmid_digit_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (digit_valid[v]),
         .in_beat   (digit_beat[v]),
         .degree    (degree[v]),
         .out_valid (digit_valid[v+1]),
         .out_beat  (digit_beat[v+1])
      );
   end

   // last binomial, range check, result fields, divider setup
   always_comb begin
      fold_full = PMUL_W'(digit_beat[NV].prod) * PMUL_W'(digit_beat[NV].binom);
      fold_prod = fold_full[bmid_pkg::PROD_W-1:0];
      fold_sat  = digit_beat[NV].psat | (|fold_full[PMUL_W-1:bmid_pkg::PROD_W]);
      fold_oor  = digit_beat[NV].rem != '0;
      fold_beat_in.rem     = '0;
      fold_beat_in.quo     = {1'b1, {(bmid_pkg::DIV_W-1){1'b0}}};
      fold_beat_in.divisor = fold_prod[bmid_pkg::DIV_W-1:0];
      fold_beat_in.big     = |fold_prod[bmid_pkg::PROD_W-1:bmid_pkg::DIV_W];
      fold_beat_in.res.index_out_of_range = fold_oor;
      fold_beat_in.res.inverse_weight     = '0;
      if (fold_oor) begin
         fold_beat_in.res.product_saturated = 1'b0;
         fold_beat_in.res.binomial_product  = '0;
         fold_beat_in.res.degree_sum        = '0;
         fold_beat_in.res.is_linear         = 1'b0;
         fold_beat_in.res.at_vertex         = 1'b0;
         fold_beat_in.res.exponents         = '0;
      end else begin
         fold_beat_in.res.product_saturated = fold_sat;
         fold_beat_in.res.binomial_product  = fold_sat ? '1 : fold_prod;
         fold_beat_in.res.degree_sum        = digit_beat[NV].sum;
         fold_beat_in.res.is_linear         = digit_beat[NV].sum <= bmid_pkg::SUM_W'(1);
         fold_beat_in.res.at_vertex         = digit_beat[NV].vertex;
         fold_beat_in.res.exponents         = digit_beat[NV].exps;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (enable) begin
         fold_valid_ff <= digit_valid[NV];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         fold_beat_ff <= fold_beat_in;
      end
   end

   assign div_valid[0] = fold_valid_ff;
   assign div_beat[0]  = fold_beat_ff;

   for (genvar s = 0; s < NDIV; s++) begin : g_div
      bmid_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (div_valid[s]),
         .in_beat   (div_beat[s]),
         .out_valid (div_valid[s+1]),
         .out_beat  (div_beat[s+1])
      );
   end

   // round half up: (floor(2^32/p) + 1) / 2
   always_comb begin
      rounded  = {1'b0, div_beat[NDIV].quo} + (bmid_pkg::DIV_W + 1)'(1);
      last_res = div_beat[NDIV].res;
      if (div_beat[NDIV].res.product_saturated || div_beat[NDIV].res.index_out_of_range) begin
         last_res.inverse_weight = '0;
      end else begin
         last_res.inverse_weight = rounded[bmid_pkg::INV_W:1];
      end
   end

   assign push = div_valid[NDIV] && enable;
   assign pop  = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_res_ff <= skid_valid_ff ? skid_res_ff : last_res;
      end
      if (!pop && push) begin
         skid_res_ff <= last_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(bmid_pkg::TDATA_W - bmid_pkg::RESULT_W)'(0), out_res_ff};

endmodule

// ----- rtl/bmid_checker.sv -----
// Port-level checks for the decoder, bound to the top level.
module bmid_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bmid_pkg::TDATA_W-1:0]       rsp_tdata
);

   bmid_pkg::bmid_result_type res;

   assign res = bmid_pkg::bmid_result_type'(rsp_tdata[bmid_pkg::RESULT_W-1:0]);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.index_out_of_range |->
         rsp_tdata[bmid_pkg::RESULT_W-2:0] == '0)
      else $error("out-of-range beat carries nonzero fields");

   a_sat_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.product_saturated |->
         (res.binomial_product == '1) && (res.inverse_weight == '0))
      else $error("saturated beat has wrong product or inverse");

   a_linear_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !res.index_out_of_range |->
         res.is_linear == (res.degree_sum <= bmid_pkg::SUM_W'(1)))
      else $error("is_linear disagrees with degree_sum");

endmodule

bind bernstein_multi_index_decode_core bmid_checker u_bmid_checker (.*);
